### design/sel_pkg.sv
// Shared types and constants for the strobe envelope light controller.
// Used by the controller, the datapath, the divider lanes and the top level.
package sel_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned NOW_W          = 32;
  localparam int unsigned COLOR_W        = 8;
  localparam int unsigned DUR_W          = 16;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned QUOT_W         = 8;
  localparam int unsigned NUM_W          = DUR_W + QUOT_W;
  localparam int unsigned STEP_W         = $clog2(QUOT_W);
  localparam int unsigned SPAN_SHIFT     = 5;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STROBE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FEVER  = 2'd2;

  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd255;
  localparam logic [DUR_W-1:0]   RESET_SDUR   = 16'd600;
  localparam logic [DUR_W-1:0]   RESET_FDUR   = 16'd1500;
  localparam logic [COLOR_W-1:0] SPEED_STROBE = 8'd1;
  localparam logic [NUM_W-1:0]   SPEED_TOP    = 24'd132;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED       = 3'd0,
    REG_GREEN     = 3'd1,
    REG_BLUE      = 3'd2,
    REG_DIMMER    = 3'd3,
    REG_STROBE_DUR = 3'd4,
    REG_FEVER_DUR = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic accept;
    logic xfer;
    logic clamp;
    logic load;
    logic step;
    logic out_load;
  } sel_cmd_t;

  typedef struct packed {
    logic out_free;
  } sel_status_t;

endpackage

### design/sel_div_lane.sv
// One restoring divider lane: one quotient bit per step, 8-bit quotient.
// Depends on sel_pkg; the shifted divisor is supplied by the datapath.
module sel_div_lane (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [sel_pkg::NUM_W-1:0]   num_i,
  input  logic [sel_pkg::NUM_W-1:0]   divisor_i,
  output logic [sel_pkg::QUOT_W-1:0]  quot_o
);
  import sel_pkg::*;

  logic [NUM_W-1:0]  rem_q;
  logic [QUOT_W-1:0] quot_q;
  logic              fits;

  assign fits   = rem_q >= divisor_i;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q  <= num_i;
      quot_q <= '0;
    end else if (step_i) begin
      if (fits) begin
        rem_q <= rem_q - divisor_i;
      end
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

endmodule

### design/sel_ctrl.sv
// Sequencer for the light controller: steps one item through mode update,
// clamp, numerator load, eight divide steps and the output register.
// Depends on sel_pkg for the command and status structs.
module sel_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sel_pkg::sel_status_t  status_i,
  output sel_pkg::sel_cmd_t     cmd_o
);
  import sel_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_XFER  = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_XFER;
        end
      end
      S_XFER: begin
        cmd_o.xfer = 1'b1;
        state_d    = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = STEP_W'(QUOT_W - 1);
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### design/sel_datapath.sv
// Datapath: configuration registers, mode and start-time state, elapsed time
// clamp, numerators, three divider lanes and the output register.
// Depends on sel_pkg and sel_div_lane.
module sel_datapath #(
  parameter int unsigned TIME_WIDTH = sel_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sel_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sel_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [sel_pkg::NOW_W-1:0]       now_ms_i,
  input  logic                            clap_seen_i,
  input  logic                            fever_seen_i,
  input  logic                            fever_stop_seen_i,
  input  sel_pkg::sel_cmd_t               cmd_i,
  output sel_pkg::sel_status_t            status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [sel_pkg::COLOR_W-1:0]     dimmer_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     red_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     green_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     blue_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     white_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     strobe_speed_o,
  output logic [sel_pkg::MODE_W-1:0]      mode_after_o
);
  import sel_pkg::*;

  localparam int unsigned LANES_N = 3;

  // configuration
  logic [COLOR_W-1:0] red_q, green_q, blue_q, dim_q;
  logic [DUR_W-1:0]   sdur_q, fdur_q;
  logic [DUR_W-1:0]   ds, df;

  // item and state
  logic [TIME_WIDTH-1:0] now_q;
  logic                  clap_q, fev_q, stop_q;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [TIME_WIDTH-1:0] sstart_q, sstart_d, fstart_q, fstart_d;
  logic [TIME_WIDTH-1:0] es_raw, ef_raw, e_d, e_q;
  logic                  s_restart, f_restart, fever_over;

  // clamp and divide
  logic [MODE_W-1:0]  kind_q;
  logic [DUR_W-1:0]   dur, ec, dur_q, ec_q, diff_q;
  logic               reached;
  logic [NUM_W-1:0]   divisor_q;
  logic [NUM_W-1:0]   spd_num;
  logic [NUM_W-1:0]   num [LANES_N];
  logic [QUOT_W-1:0]  quot [LANES_N];

  // output register
  logic               out_valid_q;
  logic [COLOR_W-1:0] dim_out_q, red_out_q, green_out_q, blue_out_q, spd_out_q;
  logic [MODE_W-1:0]  mode_out_q;

  assign ds = (sdur_q == '0) ? DUR_W'(1) : sdur_q;
  assign df = (fdur_q == '0) ? DUR_W'(1) : fdur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= RESET_COLOR;
      green_q <= RESET_COLOR;
      blue_q  <= RESET_COLOR;
      dim_q   <= RESET_COLOR;
      sdur_q  <= RESET_SDUR;
      fdur_q  <= RESET_FDUR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RED:        red_q   <= cfg_data_i[COLOR_W-1:0];
        REG_GREEN:      green_q <= cfg_data_i[COLOR_W-1:0];
        REG_BLUE:       blue_q  <= cfg_data_i[COLOR_W-1:0];
        REG_DIMMER:     dim_q   <= cfg_data_i[COLOR_W-1:0];
        REG_STROBE_DUR: sdur_q  <= cfg_data_i[DUR_W-1:0];
        REG_FEVER_DUR:  fdur_q  <= cfg_data_i[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q  <= TIME_WIDTH'(now_ms_i);
      clap_q <= clap_seen_i;
      fev_q  <= fever_seen_i;
      stop_q <= fever_stop_seen_i;
    end
  end

  // mode transition, elapsed times wrap modulo 2^TIME_WIDTH
  assign es_raw     = now_q - sstart_q;
  assign ef_raw     = now_q - fstart_q;
  assign fever_over = ef_raw > TIME_WIDTH'(df);

  always_comb begin
    mode_d    = mode_q;
    sstart_d  = sstart_q;
    fstart_d  = fstart_q;
    s_restart = 1'b0;
    f_restart = 1'b0;
    case (mode_q)
      MODE_STROBE: begin
        if (fev_q) begin
          mode_d    = MODE_FEVER;
          f_restart = 1'b1;
        end else if (clap_q) begin
          s_restart = 1'b1;
        end
      end
      MODE_FEVER: begin
        // stop wins over a fever start in the same item
        if (stop_q || fever_over) begin
          mode_d = MODE_IDLE;
        end else if (fev_q) begin
          f_restart = 1'b1;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (fev_q) begin
          mode_d    = MODE_FEVER;
          f_restart = 1'b1;
        end else if (clap_q) begin
          mode_d    = MODE_STROBE;
          s_restart = 1'b1;
        end
      end
    endcase
    if (s_restart) begin
      sstart_d = now_q;
    end
    if (f_restart) begin
      fstart_d = now_q;
    end
    if (mode_d == MODE_FEVER) begin
      e_d = f_restart ? '0 : ef_raw;
    end else begin
      e_d = s_restart ? '0 : es_raw;
    end
  end

  // clamp elapsed time to the active duration
  assign dur     = (mode_q == MODE_FEVER) ? df : ds;
  assign reached = e_q >= TIME_WIDTH'(dur);
  assign ec      = reached ? dur : e_q[DUR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      sstart_q <= '0;
      fstart_q <= '0;
    end else if (cmd_i.xfer) begin
      mode_q   <= mode_d;
      sstart_q <= sstart_d;
      fstart_q <= fstart_d;
    end else if (cmd_i.clamp && mode_q == MODE_STROBE && reached) begin
      // fade done: drop back to idle, this item still shows the strobe values
      mode_q <= MODE_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xfer) begin
      e_q <= e_d;
    end
    if (cmd_i.clamp) begin
      kind_q <= mode_q;
      dur_q  <= dur;
      ec_q   <= ec;
      diff_q <= dur - ec;
    end
    if (cmd_i.load) begin
      divisor_q <= NUM_W'(dur_q) << (QUOT_W - 1);
    end else if (cmd_i.step) begin
      divisor_q <= divisor_q >> 1;
    end
  end

  assign spd_num = NUM_W'(dur_q) * SPEED_TOP - (NUM_W'(ec_q) << SPAN_SHIFT);
  assign num[0]  = (kind_q == MODE_FEVER) ? spd_num : NUM_W'(red_q) * NUM_W'(diff_q);
  assign num[1]  = NUM_W'(green_q) * NUM_W'(diff_q);
  assign num[2]  = NUM_W'(blue_q) * NUM_W'(diff_q);

  for (genvar g = 0; g < LANES_N; g++) begin : g_lane
    sel_div_lane u_lane (
      .clk_i     (clk_i),
      .load_i    (cmd_i.load),
      .step_i    (cmd_i.step),
      .num_i     (num[g]),
      .divisor_i (divisor_q),
      .quot_o    (quot[g])
    );
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mode_out_q <= mode_q;
      case (kind_q)
        MODE_STROBE: begin
          dim_out_q   <= dim_q;
          red_out_q   <= quot[0];
          green_out_q <= quot[1];
          blue_out_q  <= quot[2];
          spd_out_q   <= SPEED_STROBE;
        end
        MODE_FEVER: begin
          dim_out_q   <= dim_q;
          red_out_q   <= red_q;
          green_out_q <= green_q;
          blue_out_q  <= blue_q;
          spd_out_q   <= quot[0];
        end
        default: begin
          dim_out_q   <= '0;
          red_out_q   <= '0;
          green_out_q <= '0;
          blue_out_q  <= '0;
          spd_out_q   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dimmer_level_o = dim_out_q;
  assign red_level_o    = red_out_q;
  assign green_level_o  = green_out_q;
  assign blue_level_o   = blue_out_q;
  assign white_level_o  = '0;
  assign strobe_speed_o = spd_out_q;
  assign mode_after_o   = mode_out_q;

endmodule

### design/strobe_envelope_light_controller.sv
// Strobe envelope light controller, top level. Depends on sel_pkg, sel_ctrl, sel_datapath.
// From input accept to result valid, an item passes mode update, clamp, numerator
// load, 8 restoring divide steps and the output register, which waits until it is free.
// One item at a time: a new item is accepted only after the last one is loaded into the
// output register. The next item is accepted while a result still waits.
// Reset (rst_ni low, asynchronous): idle mode, start times 0, colors 255, durations 600/1500.
module strobe_envelope_light_controller #(
  parameter int unsigned TIME_WIDTH = sel_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sel_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sel_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sel_pkg::NOW_W-1:0]       now_ms_i,
  input  logic                            clap_seen_i,
  input  logic                            fever_seen_i,
  input  logic                            fever_stop_seen_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sel_pkg::COLOR_W-1:0]     dimmer_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     red_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     green_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     blue_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     white_level_o,
  output logic [sel_pkg::COLOR_W-1:0]     strobe_speed_o,
  output logic [sel_pkg::MODE_W-1:0]      mode_after_o
);
  import sel_pkg::*;

  sel_cmd_t    cmd;
  sel_status_t status;

  sel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sel_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .now_ms_i          (now_ms_i),
    .clap_seen_i       (clap_seen_i),
    .fever_seen_i      (fever_seen_i),
    .fever_stop_seen_i (fever_stop_seen_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .dimmer_level_o    (dimmer_level_o),
    .red_level_o       (red_level_o),
    .green_level_o     (green_level_o),
    .blue_level_o      (blue_level_o),
    .white_level_o     (white_level_o),
    .strobe_speed_o    (strobe_speed_o),
    .mode_after_o      (mode_after_o)
  );

endmodule

### bench/tb_top.sv
// Self-checking bench for strobe_envelope_light_controller: frame items with random gaps
// and output stalls, results checked against a cycle-free light model in a scoreboard.
// Depends on sel_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sel_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] dimmer;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] white;
    logic [COLOR_W-1:0] speed;
    logic [MODE_W-1:0]  mode;
  } light_frame_t;

  // Light model: mirrors the registers and the mode machine, queues one frame per item.
  class light_scoreboard;
    logic [COLOR_W-1:0] red, green, blue, dimmer;
    logic [DUR_W-1:0]   strobe_dur, fever_dur;
    logic [MODE_W-1:0]  mode;
    logic [NOW_W-1:0]   strobe_t0, fever_t0;
    light_frame_t       frames_q[$];
    int                 mismatches;

    function new();
      red = RESET_COLOR;
      green = RESET_COLOR;
      blue = RESET_COLOR;
      dimmer = RESET_COLOR;
      strobe_dur = RESET_SDUR;
      fever_dur = RESET_FDUR;
      mode = MODE_IDLE;
      strobe_t0 = '0;
      fever_t0 = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RED:        red = val[COLOR_W-1:0];
        REG_GREEN:      green = val[COLOR_W-1:0];
        REG_BLUE:       blue = val[COLOR_W-1:0];
        REG_DIMMER:     dimmer = val[COLOR_W-1:0];
        REG_STROBE_DUR: strobe_dur = val[DUR_W-1:0];
        REG_FEVER_DUR:  fever_dur = val[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return frames_q.size();
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endfunction

    function void note_frame(logic [NOW_W-1:0] now, logic clap, logic fev, logic stop);
      logic [63:0]      ds, df, e;
      logic [NOW_W-1:0] since;
      light_frame_t     fr;
      ds = (strobe_dur == 0) ? 64'd1 : 64'(strobe_dur);
      df = (fever_dur == 0) ? 64'd1 : 64'(fever_dur);
      fr = '0;
      case (mode)
        MODE_STROBE: begin
          if (fev) begin
            mode = MODE_FEVER;
            fever_t0 = now;
          end else if (clap) begin
            strobe_t0 = now;
          end
        end
        MODE_FEVER: begin
          since = now - fever_t0;
          if (stop || 64'(since) > df) mode = MODE_IDLE;
          else if (fev) fever_t0 = now;
        end
        default: begin
          mode = MODE_IDLE;
          if (fev) begin
            mode = MODE_FEVER;
            fever_t0 = now;
          end else if (clap) begin
            mode = MODE_STROBE;
            strobe_t0 = now;
          end
        end
      endcase
      if (mode == MODE_STROBE) begin
        since = now - strobe_t0;
        e = 64'(since);
        // fade finished: the frame still carries strobe values, mode drops to idle
        if (e >= ds) begin
          e = ds;
          mode = MODE_IDLE;
        end
        fr.dimmer = dimmer;
        fr.red = 8'((64'(red) * (ds - e)) / ds);
        fr.green = 8'((64'(green) * (ds - e)) / ds);
        fr.blue = 8'((64'(blue) * (ds - e)) / ds);
        fr.speed = SPEED_STROBE;
      end else if (mode == MODE_FEVER) begin
        since = now - fever_t0;
        e = (64'(since) > df) ? df : 64'(since);
        fr.dimmer = dimmer;
        fr.red = red;
        fr.green = green;
        fr.blue = blue;
        fr.speed = 8'((64'd132 * df - 64'd32 * e) / df);
      end
      fr.mode = mode;
      frames_q.push_back(fr);
    endfunction

    function void check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endfunction

    function void check_frame(light_frame_t got);
      light_frame_t want;
      if (frames_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = frames_q.pop_front();
      check_field("dimmer", got.dimmer, want.dimmer);
      check_field("red", got.red, want.red);
      check_field("green", got.green, want.green);
      check_field("blue", got.blue, want.blue);
      check_field("white", got.white, want.white);
      check_field("strobe_speed", got.speed, want.speed);
      check_field("mode_after", 8'(got.mode), 8'(want.mode));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [NOW_W-1:0]      now_ms_i = '0;
  logic                  clap_seen_i = 1'b0;
  logic                  fever_seen_i = 1'b0;
  logic                  fever_stop_seen_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COLOR_W-1:0]    dimmer_level_o, red_level_o, green_level_o, blue_level_o;
  logic [COLOR_W-1:0]    white_level_o, strobe_speed_o;
  logic [MODE_W-1:0]     mode_after_o;

  light_scoreboard  lights = new();
  logic [NOW_W-1:0] clock_ms = '0;
  bit               tx_steady = 1'b0;
  bit               rx_steady = 1'b0;

  always #6 clk_i = ~clk_i;

  strobe_envelope_light_controller u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .now_ms_i          (now_ms_i),
    .clap_seen_i       (clap_seen_i),
    .fever_seen_i      (fever_seen_i),
    .fever_stop_seen_i (fever_stop_seen_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .dimmer_level_o    (dimmer_level_o),
    .red_level_o       (red_level_o),
    .green_level_o     (green_level_o),
    .blue_level_o      (blue_level_o),
    .white_level_o     (white_level_o),
    .strobe_speed_o    (strobe_speed_o),
    .mode_after_o      (mode_after_o)
  );

  // All driver tasks start and end on a falling edge.
  task automatic send_frame(logic [NOW_W-1:0] now, logic clap, logic fev, logic stop);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i <= now;
    clap_seen_i <= clap;
    fever_seen_i <= fev;
    fever_stop_seen_i <= stop;
    do @(posedge clk_i); while (!in_ready_o);
    lights.note_frame(now, clap, fev, stop);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    lights.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (lights.pending() != 0) @(negedge clk_i);
  endtask

  // Registers change only with the pipe empty.
  task automatic program_lights(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] dim,
                                logic [15:0] sdur, logic [15:0] fdur);
    wait_drained();
    write_reg(REG_RED, 16'(r));
    write_reg(REG_GREEN, 16'(g));
    write_reg(REG_BLUE, 16'(b));
    write_reg(REG_DIMMER, 16'(dim));
    write_reg(REG_STROBE_DUR, sdur);
    write_reg(REG_FEVER_DUR, fdur);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly a steady clock with sparse events; now and then a time jump or flag noise.
  task automatic run_frames(int count, int unsigned max_step);
    int unsigned pick;
    logic        clap, fev, stop;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) clock_ms = $urandom();
      else if (pick < 8) clock_ms = clock_ms - $urandom_range(1, max_step + 1);
      else clock_ms = clock_ms + $urandom_range(0, max_step);
      if ($urandom_range(0, 19) == 0) begin
        clap = 1'($urandom());
        fev = 1'($urandom());
        stop = 1'($urandom());
      end else begin
        clap = ($urandom_range(0, 99) < 15);
        fev = ($urandom_range(0, 99) < 7);
        stop = ($urandom_range(0, 99) < 5);
      end
      send_frame(clock_ms, clap, fev, stop);
    end
  endtask

  initial begin
    int unsigned sd, fd;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames at reset settings (strobe 600 ms, fever 1500 ms)
    send_frame(32'd0, 1'b0, 1'b0, 1'b0);
    send_frame(32'd100, 1'b1, 1'b0, 1'b0);
    send_frame(32'd400, 1'b0, 1'b0, 1'b0);
    send_frame(32'd500, 1'b1, 1'b0, 1'b0);
    send_frame(32'd600, 1'b0, 1'b0, 1'b1);
    send_frame(32'd1100, 1'b0, 1'b0, 1'b0);
    send_frame(32'd2000, 1'b1, 1'b1, 1'b0);
    send_frame(32'd2750, 1'b0, 1'b0, 1'b0);
    send_frame(32'd3000, 1'b0, 1'b1, 1'b0);
    send_frame(32'd3100, 1'b0, 1'b1, 1'b1);
    send_frame(32'd3200, 1'b0, 1'b1, 1'b0);
    send_frame(32'd4700, 1'b0, 1'b0, 1'b0);
    send_frame(32'd4701, 1'b0, 1'b0, 1'b0);
    send_frame(32'd5000, 1'b1, 1'b0, 1'b0);
    send_frame(32'd5100, 1'b1, 1'b1, 1'b0);
    send_frame(32'd5200, 1'b1, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1);
    send_frame(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0);
    send_frame(32'h0000_0010, 1'b0, 1'b0, 1'b0);
    send_frame(32'hFFFF_FF00, 1'b0, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0000_0005, 1'b0, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0);
    // hold the sender until the pipe is empty once
    wait_drained();
    send_frame(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);

    clock_ms = 32'd10_000;
    run_frames(220, 120);

    tx_steady = 1'b1;
    rx_steady = 1'b1;
    program_lights(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    run_frames(140, 12000);

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    // zero durations count as one millisecond
    program_lights(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    run_frames(100, 2);

    sd = $urandom_range(1, 50);
    fd = $urandom_range(1, 100);
    program_lights(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                   16'(sd), 16'(fd));
    run_frames(230, 20);

    rx_steady = 1'b1;
    sd = $urandom_range(1, 65535);
    fd = $urandom_range(1, 65535);
    program_lights(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                   16'(sd), 16'(fd));
    run_frames(150, ((sd > fd) ? sd : fd) / 4);

    rx_steady = 1'b0;
    program_lights(8'd1, 8'd128, 8'd254, 8'd128, 16'd1, 16'hFFFF);
    run_frames(100, 3);

    program_lights(8'd255, 8'd255, 8'd255, 8'd255, 16'd600, 16'd1500);
    run_frames(80, 150);

    wait_drained();
    repeat (24) @(negedge clk_i);
    if (lights.mismatches == 0 && lights.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, one check per accepted result.
  initial begin
    int stall;
    light_frame_t got;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.dimmer = dimmer_level_o;
      got.red = red_level_o;
      got.green = green_level_o;
      got.blue = blue_level_o;
      got.white = white_level_o;
      got.speed = strobe_speed_o;
      got.mode = mode_after_o;
      lights.check_frame(got);
      @(negedge clk_i);
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
design/sel_pkg.sv
design/sel_div_lane.sv
design/sel_ctrl.sv
design/sel_datapath.sv
design/strobe_envelope_light_controller.sv
bench/tb_top.sv
